// ----- sv/lrms_pkg.sv -----
// Package for the LQR roll motor speed block: item types, widths, register codes,
// reset values and small helpers. No dependencies.
package lrms_pkg;

   localparam int unsigned FRAC_BITS_DEF   = 16;
   localparam int unsigned SAMPLE_RATE_DEF = 1000;

   localparam int DATA_W    = 24;
   localparam int INVK_W    = 20;
   localparam int ERR_W     = DATA_W + 1;
   localparam int MUL_W     = 26;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 72;
   localparam int MAG_W     = 50;
   localparam int HALF_W    = MAG_W / 2;
   localparam int OUT_FRAC  = 8;
   localparam int RAD_W     = 33;
   localparam int ROOT_W    = 17;
   localparam int SPEED_W   = ROOT_W + 1;
   localparam int CSR_IDX_W = 3;

   localparam logic [RAD_W-1:0]  RAD_CAP     = 33'd5898393601;
   localparam logic [ROOT_W-1:0] SPEED_LIMIT = 17'd76800;

   localparam logic signed [ACC_W-1:0] VEL_MAX_ACC = ACC_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] VEL_MIN_ACC = ACC_W'(-(2 ** (DATA_W - 1)));
   localparam logic signed [ACC_W-1:0] RAD_CAP_ACC = ACC_W'(RAD_CAP);
   localparam logic signed [DATA_W-1:0] DATA_MAX   = DATA_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [DATA_W-1:0] DATA_MIN   = DATA_W'(-(2 ** (DATA_W - 1)));

   localparam logic signed [SPEED_W-1:0] MOTOR_MAX = SPEED_W'(SPEED_LIMIT);
   localparam logic signed [SPEED_W-1:0] MOTOR_MIN = -MOTOR_MAX;

   localparam logic signed [DATA_W-1:0] RST_GAIN_PEND_ANGLE = DATA_W'(-4635951);
   localparam logic signed [DATA_W-1:0] RST_GAIN_PEND_RATE  = DATA_W'(-735032);
   localparam logic signed [DATA_W-1:0] RST_GAIN_POSITION   = DATA_W'(29308);
   localparam logic signed [DATA_W-1:0] RST_GAIN_VELOCITY   = DATA_W'(192728);
   localparam logic signed [DATA_W-1:0] RST_GAIN_BODY_ANGLE = DATA_W'(3212909);
   localparam logic signed [DATA_W-1:0] RST_GAIN_BODY_RATE  = DATA_W'(183193);
   localparam logic signed [DATA_W-1:0] RST_POS_SETPOINT    = DATA_W'(6554);
   localparam logic [INVK_W-1:0]        RST_INV_THRUST      = INVK_W'(116978);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_PEND_ANGLE = 3'd0,
      CSR_GAIN_PEND_RATE  = 3'd1,
      CSR_GAIN_POSITION   = 3'd2,
      CSR_GAIN_VELOCITY   = 3'd3,
      CSR_GAIN_BODY_ANGLE = 3'd4,
      CSR_GAIN_BODY_RATE  = 3'd5,
      CSR_POS_SETPOINT    = 3'd6,
      CSR_INV_THRUST      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_HIGH
   } acc_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pend_angle;
      logic signed [DATA_W-1:0] pend_rate;
      logic signed [DATA_W-1:0] lateral_position;
      logic signed [DATA_W-1:0] body_angle;
      logic signed [DATA_W-1:0] body_rate;
   } req_item_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] motor_speed;
      logic                      clamped;
   } rsp_item_type;

   function automatic logic signed [ERR_W-1:0] sext_err(input logic signed [DATA_W-1:0] x);
      return {x[DATA_W-1], x};
   endfunction

   function automatic logic signed [ERR_W-1:0] neg_err(input logic signed [DATA_W-1:0] x);
      return ERR_W'(0) - sext_err(x);
   endfunction

endpackage

// ----- sv/lqr_roll_motor_speed_top.sv -----
// Top level of the LQR roll motor speed block: registers, sequencer, output register.
// Depends on lrms_pkg, lrms_mac and lrms_isqrt.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_item (req_item_type)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_item (rsp_item_type)
//   csr     | in        | csr_we                 | csr_index, csr_wdata
//
// Each item runs nine products on the shared MAC, then the root recurrence.
// Reset is synchronous; it clears control state and previous position and loads the
// register reset values.
// req_stall is high while an item is in work. A stalled result only holds the
// sequencer at its last step; the next item is taken once the result is loaded.
module lqr_roll_motor_speed_top import lrms_pkg::*; #(
   parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
   parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int RAD_SHIFT = 2 * FRAC_BITS - 2 * OUT_FRAC;

   typedef enum logic [3:0] {
      S_IDLE,
      S_VEL,
      S_VEL_WAIT,
      S_VEL_SAT,
      S_EFF,
      S_EFF_WAIT,
      S_MAG,
      S_RAD,
      S_RAD_WAIT,
      S_RAD_SAT,
      S_ROOT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] gain_pend_angle_ff, gain_pend_rate_ff, gain_position_ff;
   logic signed [DATA_W-1:0] gain_velocity_ff, gain_body_angle_ff, gain_body_rate_ff;
   logic signed [DATA_W-1:0] pos_setpoint_ff;
   logic [INVK_W-1:0]        inv_thrust_ff;

   req_item_type             item_ff, item_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [ERR_W-1:0]  diff_ff, diff_in;
   logic signed [DATA_W-1:0] vel_ff, vel_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [CSR_IDX_W-1:0]     cnt_ff, cnt_in;
   logic                     half_ff, half_in;
   logic [ROOT_W-1:0]        speed_ff, speed_in;
   logic                     clamp_ff, clamp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   acc_op_type               acc_op;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_abs;
   logic signed [ACC_W-1:0]  acc_shr;
   logic signed [DATA_W-1:0] gain_sel;
   logic signed [ERR_W-1:0]  err_sel;
   logic                     root_start;
   logic [RAD_W-1:0]         radicand;
   logic                     root_done;
   logic [ROOT_W-1:0]        root;
   logic [SPEED_W-1:0]       speed_ext;

   lrms_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .acc_op (acc_op),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .acc    (acc)
   );

   lrms_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      case (cnt_ff)
         CSR_GAIN_PEND_ANGLE: begin
            gain_sel = gain_pend_angle_ff;
            err_sel  = neg_err(item_ff.pend_angle);
         end
         CSR_GAIN_PEND_RATE: begin
            gain_sel = gain_pend_rate_ff;
            err_sel  = neg_err(item_ff.pend_rate);
         end
         CSR_GAIN_POSITION: begin
            gain_sel = gain_position_ff;
            err_sel  = sext_err(pos_setpoint_ff) - sext_err(item_ff.lateral_position);
         end
         CSR_GAIN_VELOCITY: begin
            gain_sel = gain_velocity_ff;
            err_sel  = neg_err(vel_ff);
         end
         CSR_GAIN_BODY_ANGLE: begin
            gain_sel = gain_body_angle_ff;
            err_sel  = neg_err(item_ff.body_angle);
         end
         CSR_GAIN_BODY_RATE: begin
            gain_sel = gain_body_rate_ff;
            err_sel  = neg_err(item_ff.body_rate);
         end
         default: begin
            gain_sel = '0;
            err_sel  = '0;
         end
      endcase
   end

   assign acc_abs   = acc[ACC_W-1] ? -acc : acc;
   assign acc_shr   = acc >>> RAD_SHIFT;
   assign radicand  = (acc_shr > RAD_CAP_ACC) ? RAD_CAP : acc_shr[RAD_W-1:0];
   assign speed_ext = {1'b0, speed_ff};

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      vel_in       = vel_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      half_in      = half_ff;
      speed_in     = speed_ff;
      clamp_in     = clamp_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      acc_op       = ACC_HOLD;
      mul_a        = '0;
      mul_b        = '0;
      root_start   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               diff_in  = sext_err(req_item.lateral_position) - sext_err(prev_ff);
               prev_in  = req_item.lateral_position;
               state_in = S_VEL;
            end
         end
         S_VEL: begin
            mul_a    = MUL_W'(diff_ff);
            mul_b    = MUL_W'(SAMPLE_RATE);
            acc_op   = ACC_LOAD;
            state_in = S_VEL_WAIT;
         end
         S_VEL_WAIT: begin
            state_in = S_VEL_SAT;
         end
         S_VEL_SAT: begin
            if (acc > VEL_MAX_ACC) begin
               vel_in = DATA_MAX;
            end else if (acc < VEL_MIN_ACC) begin
               vel_in = DATA_MIN;
            end else begin
               vel_in = acc[DATA_W-1:0];
            end
            cnt_in   = CSR_GAIN_PEND_ANGLE;
            state_in = S_EFF;
         end
         S_EFF: begin
            mul_a  = MUL_W'(gain_sel);
            mul_b  = MUL_W'(err_sel);
            acc_op = (cnt_ff == CSR_GAIN_PEND_ANGLE) ? ACC_LOAD : ACC_ADD;
            cnt_in = cnt_ff + CSR_IDX_W'(1);
            if (cnt_ff == CSR_GAIN_BODY_RATE) begin
               state_in = S_EFF_WAIT;
            end
         end
         S_EFF_WAIT: begin
            state_in = S_MAG;
         end
         S_MAG: begin
            neg_in   = acc[ACC_W-1];
            mag_in   = acc_abs[MAG_W-1:0];
            half_in  = 1'b0;
            state_in = S_RAD;
         end
         S_RAD: begin
            mul_b = MUL_W'(inv_thrust_ff);
            if (!half_ff) begin
               mul_a   = MUL_W'(mag_ff[HALF_W-1:0]);
               acc_op  = ACC_LOAD;
               half_in = 1'b1;
            end else begin
               mul_a    = MUL_W'(mag_ff[MAG_W-1:HALF_W]);
               acc_op   = ACC_ADD_HIGH;
               state_in = S_RAD_WAIT;
            end
         end
         S_RAD_WAIT: begin
            state_in = S_RAD_SAT;
         end
         S_RAD_SAT: begin
            root_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (root_done) begin
               if (root > SPEED_LIMIT) begin
                  speed_in = SPEED_LIMIT;
                  clamp_in = 1'b1;
               end else begin
                  speed_in = root;
                  clamp_in = 1'b0;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_item_in.motor_speed = neg_ff ? SPEED_W'(0) - speed_ext : speed_ext;
               rsp_item_in.clamped     = clamp_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      diff_ff     <= diff_in;
      vel_ff      <= vel_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      half_ff     <= half_in;
      speed_ff    <= speed_in;
      clamp_ff    <= clamp_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_pend_angle_ff <= RST_GAIN_PEND_ANGLE;
         gain_pend_rate_ff  <= RST_GAIN_PEND_RATE;
         gain_position_ff   <= RST_GAIN_POSITION;
         gain_velocity_ff   <= RST_GAIN_VELOCITY;
         gain_body_angle_ff <= RST_GAIN_BODY_ANGLE;
         gain_body_rate_ff  <= RST_GAIN_BODY_RATE;
         pos_setpoint_ff    <= RST_POS_SETPOINT;
         inv_thrust_ff      <= RST_INV_THRUST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_PEND_ANGLE: gain_pend_angle_ff <= csr_wdata;
            CSR_GAIN_PEND_RATE:  gain_pend_rate_ff  <= csr_wdata;
            CSR_GAIN_POSITION:   gain_position_ff   <= csr_wdata;
            CSR_GAIN_VELOCITY:   gain_velocity_ff   <= csr_wdata;
            CSR_GAIN_BODY_ANGLE: gain_body_angle_ff <= csr_wdata;
            CSR_GAIN_BODY_RATE:  gain_body_rate_ff  <= csr_wdata;
            CSR_POS_SETPOINT:    pos_setpoint_ff    <= csr_wdata;
            CSR_INV_THRUST:      inv_thrust_ff      <= csr_wdata[INVK_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sv/lrms_mac.sv -----
// Shared signed multiply-accumulate unit: registered 26x26 product, then accumulator.
// Depends on lrms_pkg.
module lrms_mac import lrms_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  acc_op_type               acc_op,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   acc_op_type               op_ff;

   assign prod_in = op_a * op_b;

   always_comb begin
      case (op_ff)
         ACC_HOLD:     acc_in = acc_ff;
         ACC_LOAD:     acc_in = ACC_W'(prod_ff);
         ACC_ADD:      acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_ADD_HIGH: acc_in = acc_ff + (ACC_W'(prod_ff) <<< HALF_W);
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         op_ff <= ACC_HOLD;
      end else begin
         op_ff <= acc_op;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- sv/lrms_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on lrms_pkg.
module lrms_isqrt import lrms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int SQ_W       = RAD_W + 2;
   localparam int ROOT_STEPS = (RAD_W + 1) / 2;
   localparam int CNT_W      = $clog2(ROOT_STEPS);
   localparam logic [SQ_W-1:0]  BIT_INIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1));
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_STEPS - 1);

   logic [SQ_W-1:0]  n_ff, n_in;
   logic [SQ_W-1:0]  r_ff, r_in;
   logic [SQ_W-1:0]  bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SQ_W-1:0]  trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = SQ_W'(radicand);
         r_in    = '0;
         bit_in  = BIT_INIT;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

// ----- sv/lrms_checker.sv -----
// Port-level checks for the LQR roll motor speed block, bound to the top level.
// Depends on lrms_pkg and lqr_roll_motor_speed_top.
module lrms_checker import lrms_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took no time on an item");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result loaded while item still in work");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.motor_speed <= MOTOR_MAX && rsp_item.motor_speed >= MOTOR_MIN)
      else $error("motor speed out of range");

   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.clamped |->
         rsp_item.motor_speed == MOTOR_MAX || rsp_item.motor_speed == MOTOR_MIN)
      else $error("clamp flag without limit value");

endmodule

bind lqr_roll_motor_speed_top lrms_checker u_lrms_checker (.*);
